// File: src/pairwise_attraction_force_macros.svh
// Assertion macros used by pairwise_attraction_force.
`ifndef PAIRWISE_ATTRACTION_FORCE_MACROS_SVH
`define PAIRWISE_ATTRACTION_FORCE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define PAF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define PAF_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define PAF_ASSERT(name, prop, msg)
`define PAF_ASSERT_RST(name, prop, msg)
`endif

`endif

// File: src/paf_pkg.sv
package paf_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned SQRT_STEPS = 32;  // one root bit per stage
  localparam int unsigned FDIV_STEPS = 63;  // one quotient bit per stage
  localparam int unsigned UDIV_STEPS = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRENGTH = 2'd0,
    REG_MIN_DIST = 2'd1,
    REG_ENABLED  = 2'd2
  } paf_reg_e;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_a_z;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] pos_b_z;
    logic [30:0]        mass_a;
    logic [30:0]        mass_b;
    logic               free_a;
    logic               free_b;
  } paf_req_t;

  typedef struct packed {
    logic signed [31:0] force_a_x;
    logic signed [31:0] force_a_y;
    logic signed [31:0] force_a_z;
    logic signed [31:0] force_b_x;
    logic signed [31:0] force_b_y;
    logic signed [31:0] force_b_z;
    logic               apply_a;
    logic               apply_b;
  } paf_rsp_t;

  typedef struct packed {
    logic signed [31:0] strength;
    logic [30:0]        min_distance;
    logic               enabled;
  } paf_cfg_t;

endpackage

// File: src/paf_stream_if.sv
interface paf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/paf_pipe.sv
module paf_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               in_valid_i,
  input  paf_pkg::paf_req_t  in_data_i,
  input  paf_pkg::paf_cfg_t  cfg_i,
  output logic               out_valid_o,
  output paf_pkg::paf_rsp_t  out_data_o
);
  import paf_pkg::*;

  localparam int unsigned NSTAGE = 3 + SQRT_STEPS + 1 + FDIV_STEPS + 1 + 1;
  localparam logic [30:0] U_ONE = 31'h4000_0000;  // 1.0 in Q.30

  typedef struct packed {
    logic            apa;
    logic            apb;
    logic [2:0]      dneg;
    logic [2:0][31:0] dm;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic        zero;
    logic [49:0] d2;
    logic [46:0] km;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    side_t            side;
    logic             zero;
    logic [49:0]      d2;
    logic [31:0]      len;
    logic [49:0]      frem;
    logic [62:0]      fnq;
    logic [2:0][31:0] urem;
    logic [2:0][30:0] unq;
    logic [2:0]       uovf;
  } dv_t;

  typedef struct packed {
    side_t            side;
    logic             zero;
    logic [2:0][61:0] ph;
    logic [2:0][62:0] pl;
  } ml_t;

  function automatic logic [31:0] sat_out(input logic neg, input logic [33:0] mag);
    logic [31:0] r;
    if (neg) begin
      r = (mag >= 34'h0_8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end else begin
      r = (mag >= 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return r;
  endfunction

  // Valid bits travel alongside the payload
  logic [NSTAGE-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTAGE-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[NSTAGE-1];

  // Values derived from the configuration registers
  logic [61:0] m2_full;
  logic [31:0] str_u;
  logic [45:0] m2_q;
  logic [31:0] kmag_q;
  logic        kneg_q;

  assign m2_full = cfg_i.min_distance * cfg_i.min_distance;
  assign str_u   = cfg_i.strength;

  always_ff @(posedge clk_i) begin
    m2_q   <= m2_full[61:16];
    kneg_q <= str_u[31];
    kmag_q <= str_u[31] ? (~str_u + 32'd1) : str_u;
  end

  // Stage 1: difference vector magnitudes, mass product
  logic [2:0][31:0] pa, pb;
  side_t            s1_side_d, s1_side_q;
  logic [61:0]      s1_mp_d, s1_mp_q;

  assign pa = {in_data_i.pos_a_z, in_data_i.pos_a_y, in_data_i.pos_a_x};
  assign pb = {in_data_i.pos_b_z, in_data_i.pos_b_y, in_data_i.pos_b_x};

  always_comb begin
    logic [32:0] d;
    s1_side_d.apa = cfg_i.enabled & in_data_i.free_a;
    s1_side_d.apb = cfg_i.enabled & in_data_i.free_b;
    for (int i = 0; i < 3; i++) begin
      d = {pa[i][31], pa[i]} - {pb[i][31], pb[i]};
      s1_side_d.dneg[i] = d[32];
      s1_side_d.dm[i]   = d[32] ? 32'(~d + 33'd1) : d[31:0];
    end
    s1_mp_d = in_data_i.mass_a * in_data_i.mass_b;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_side_q <= s1_side_d;
      s1_mp_q   <= s1_mp_d;
    end
  end

  // Stage 2: squares, saturated mass product
  side_t            s2_side_q;
  logic [2:0][47:0] s2_sq_d, s2_sq_q;
  logic [31:0]      s2_mm_d, s2_mm_q;

  always_comb begin
    logic [63:0] sqf;
    for (int i = 0; i < 3; i++) begin
      sqf        = s1_side_q.dm[i] * s1_side_q.dm[i];
      s2_sq_d[i] = sqf[63:16];
    end
    s2_mm_d = (s1_mp_q[61:48] != '0) ? 32'hFFFF_FFFF : s1_mp_q[47:16];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_side_q <= s1_side_q;
      s2_sq_q   <= s2_sq_d;
      s2_mm_q   <= s2_mm_d;
    end
  end

  // Stage 3: squared distance sum, strength times masses
  side_t       s3_side_q;
  logic [49:0] s3_d2_q;
  logic [46:0] s3_km_q;
  logic [63:0] kmf;

  assign kmf = kmag_q * s2_mm_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_side_q <= s2_side_q;
      s3_d2_q   <= 50'(s2_sq_q[0]) + 50'(s2_sq_q[1]) + 50'(s2_sq_q[2]);
      s3_km_q   <= kmf[62:16];
    end
  end

  // Stage 4: clamp at min distance squared, then square root stages
  sq_t         sq_q [SQRT_STEPS+1];
  sq_t         sq0_d;
  logic [49:0] d2c;

  always_comb begin
    d2c        = (s3_d2_q < {4'b0, m2_q}) ? {4'b0, m2_q} : s3_d2_q;
    sq0_d.side = s3_side_q;
    sq0_d.zero = (d2c == '0);
    sq0_d.d2   = d2c;
    sq0_d.km   = s3_km_q;
    sq0_d.rem  = '0;
    sq0_d.root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q[0] <= sq0_d;
    end
  end

  // Digit-by-digit root of d2 << 14, two radicand bits per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam int unsigned K = SQRT_STEPS - 1 - j;
    logic [63:0] v;
    logic [33:0] rsh;
    logic [33:0] trial;
    sq_t         nxt;

    always_comb begin
      v     = {sq_q[j].d2, 14'b0};
      rsh   = {sq_q[j].rem[31:0], v[2*K+1 -: 2]};
      trial = {sq_q[j].root, 2'b01};
      nxt   = sq_q[j];
      if (rsh >= trial) begin
        nxt.rem  = rsh - trial;
        nxt.root = {sq_q[j].root[30:0], 1'b1};
      end else begin
        nxt.rem  = rsh;
        nxt.root = {sq_q[j].root[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[j+1] <= nxt;
      end
    end
  end

  // Divider setup: force numerator, unit-vector numerators and overflow
  dv_t dv_q [FDIV_STEPS+1];
  dv_t dv0_d;

  always_comb begin
    logic [31:0] hi;
    dv0_d.side = sq_q[SQRT_STEPS].side;
    dv0_d.zero = sq_q[SQRT_STEPS].zero;
    dv0_d.d2   = sq_q[SQRT_STEPS].d2;
    dv0_d.len  = sq_q[SQRT_STEPS].root;
    dv0_d.frem = '0;
    dv0_d.fnq  = {sq_q[SQRT_STEPS].km, 16'b0};
    for (int i = 0; i < 3; i++) begin
      hi            = {2'b0, sq_q[SQRT_STEPS].side.dm[i][31:2]};
      dv0_d.uovf[i] = (hi >= sq_q[SQRT_STEPS].root);
      dv0_d.urem[i] = hi;
      dv0_d.unq[i]  = {sq_q[SQRT_STEPS].side.dm[i][1:0], 29'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q[0] <= dv0_d;
    end
  end

  // Restoring dividers, one quotient bit per stage (unit-vector ones only below UDIV_STEPS)
  for (genvar j = 0; j < FDIV_STEPS; j++) begin : g_div
    logic [50:0] frs;
    logic [32:0] urs;
    logic        ge;
    dv_t         nxt;

    always_comb begin
      nxt = dv_q[j];
      frs = {dv_q[j].frem, dv_q[j].fnq[62]};
      urs = '0;
      ge  = 1'b0;
      if (frs >= {1'b0, dv_q[j].d2}) begin
        nxt.frem = 50'(frs - {1'b0, dv_q[j].d2});
        nxt.fnq  = {dv_q[j].fnq[61:0], 1'b1};
      end else begin
        nxt.frem = frs[49:0];
        nxt.fnq  = {dv_q[j].fnq[61:0], 1'b0};
      end
      if (j < UDIV_STEPS) begin
        for (int i = 0; i < 3; i++) begin
          urs         = {dv_q[j].urem[i], dv_q[j].unq[i][30]};
          ge          = (urs >= {1'b0, dv_q[j].len});
          nxt.urem[i] = ge ? 32'(urs - {1'b0, dv_q[j].len}) : urs[31:0];
          nxt.unq[i]  = {dv_q[j].unq[i][29:0], ge};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[j+1] <= nxt;
      end
    end
  end

  // Multiply force magnitude by each unit component, split in two halves
  ml_t ml_d, ml_q;

  always_comb begin
    logic [30:0] u;
    ml_d.side = dv_q[FDIV_STEPS].side;
    ml_d.zero = dv_q[FDIV_STEPS].zero;
    for (int i = 0; i < 3; i++) begin
      u = (dv_q[FDIV_STEPS].uovf[i] || dv_q[FDIV_STEPS].unq[i] > U_ONE)
          ? U_ONE : dv_q[FDIV_STEPS].unq[i];
      ml_d.ph[i] = dv_q[FDIV_STEPS].fnq[62:32] * u;
      ml_d.pl[i] = dv_q[FDIV_STEPS].fnq[31:0] * u;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ml_q <= ml_d;
    end
  end

  // Recombine, sign and saturate
  logic [2:0][31:0] fa, fb;

  always_comb begin
    logic [33:0] c;
    logic [33:0] mag;
    logic        nz;
    logic        neg;
    for (int i = 0; i < 3; i++) begin
      c   = {2'b0, ml_q.ph[i][29:0], 2'b00} + {1'b0, ml_q.pl[i][62:30]};
      mag = (ml_q.ph[i][61:30] != '0) ? '1 : c;
      nz  = (mag != '0);
      neg = (kneg_q ^ ml_q.side.dneg[i]) && nz;
      fb[i] = (ml_q.zero || !ml_q.side.apb) ? '0 : sat_out(neg, mag);
      fa[i] = (ml_q.zero || !ml_q.side.apa) ? '0 : sat_out(!neg && nz, mag);
    end
  end

  always_comb begin
    out_data_o.force_a_x = fa[0];
    out_data_o.force_a_y = fa[1];
    out_data_o.force_a_z = fa[2];
    out_data_o.force_b_x = fb[0];
    out_data_o.force_b_y = fb[1];
    out_data_o.force_b_z = fb[2];
    out_data_o.apply_a   = ml_q.side.apa;
    out_data_o.apply_b   = ml_q.side.apb;
  end

endmodule

// File: src/pairwise_attraction_force.sv
// Pairwise inverse-square force between two particles, signed Q16.16.
// req_i takes one request per pair (positions, masses, free flags);
// rsp_o returns the force increments for both particles and their apply
// flags. Both channels move a request on a rising edge with valid and ready
// high. Configuration (strength, min_distance, enabled) is written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write it only while no
// request is in flight, which the block does not enforce. Every stage holds
// its own request; the 32-stage square root is followed by the 63-stage
// force divider. One request is taken per cycle while req_i.ready is high.
// Reset clears every pipeline valid bit and the output buffer; strength and
// min_distance return to 0, enabled to 1.
// Receiver stall: the result waits in the output register and one more
// goes into a skid entry; while that entry is full the pipeline freezes
// and req_i.ready is low, so no request is lost or repeated.
`include "pairwise_attraction_force_macros.svh"

module pairwise_attraction_force (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  paf_stream_if.sink                      req_i,
  paf_stream_if.source                    rsp_o,
  input  logic                            cfg_we_i,
  input  logic [paf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [paf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import paf_pkg::*;

  // Configuration registers
  paf_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strength     <= '0;
      cfg_q.min_distance <= '0;
      cfg_q.enabled      <= 1'b1;
    end else if (cfg_we_i) begin
      case (paf_reg_e'(cfg_idx_i))
        REG_STRENGTH: cfg_q.strength     <= cfg_wdata_i;
        REG_MIN_DIST: cfg_q.min_distance <= cfg_wdata_i[30:0];
        REG_ENABLED:  cfg_q.enabled      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Datapath
  logic     en;
  logic     p_valid;
  paf_rsp_t p_data;

  paf_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (req_i.valid),
    .in_data_i   (req_i.data),
    .cfg_i       (cfg_q),
    .out_valid_o (p_valid),
    .out_data_o  (p_data)
  );

  // Output register plus skid entry
  logic     out_v_d, out_v_q, skid_v_d, skid_v_q;
  paf_rsp_t out_d, out_q, skid_d, skid_q;
  logic     push;

  assign en          = !skid_v_q;
  assign req_i.ready = en;
  assign push        = en && p_valid;

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!out_v_q || rsp_o.ready) begin
      if (skid_v_q) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = push;
        out_d   = p_data;
      end
    end else if (push) begin
      skid_v_d = 1'b1;
      skid_d   = p_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign rsp_o.valid = out_v_q;
  assign rsp_o.data  = out_q;

  // Checks
  `PAF_ASSERT(a_skid_needs_out, skid_v_q |-> out_v_q, "skid entry full with output empty")
  `PAF_ASSERT(a_skid_after_stall, $rose(skid_v_q) |-> $past(out_v_q && !rsp_o.ready), "skid filled without a stall")
  `PAF_ASSERT(a_no_apply_zero, (out_v_q && !out_q.apply_a) |-> (out_q.force_a_x == '0 && out_q.force_a_y == '0 && out_q.force_a_z == '0), "force on a particle that is not applied")
  `PAF_ASSERT(a_out_held, (out_v_q && !rsp_o.ready) |=> (out_v_q && $stable(out_q)), "stalled response changed")

endmodule

// File: tb/paf_force_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts every force
// increment and compares the responses in order.
module paf_force_checker
  import paf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  input  paf_req_t              req_data_i,
  input  logic                  rsp_valid_i,
  input  logic                  rsp_ready_i,
  input  paf_rsp_t              rsp_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    errors_o,
  output int                    pending_o
);

  logic signed [31:0] strength_q;
  logic [30:0]        min_dist_q;
  logic               enabled_q;
  paf_rsp_t           force_q[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_force(bit neg, longint unsigned m);
    if (neg) return (m >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
    return (m >= 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
  endfunction

  // Force increments for one particle pair under the current registers
  function automatic paf_rsp_t pair_force(paf_req_t r);
    paf_rsp_t        res;
    longint          dv[3];
    longint unsigned dm[3];
    longint unsigned d2, m2, len, mm, kmag, km, fmag, u, c, ph;
    logic signed [31:0] fa[3], fb[3];
    bit              kneg, neg, apa, apb;
    res = '0;
    apa = enabled_q && r.free_a;
    apb = enabled_q && r.free_b;
    res.apply_a = apa;
    res.apply_b = apb;
    if (!apa && !apb) return res;
    dv[0] = longint'(r.pos_a_x) - longint'(r.pos_b_x);
    dv[1] = longint'(r.pos_a_y) - longint'(r.pos_b_y);
    dv[2] = longint'(r.pos_a_z) - longint'(r.pos_b_z);
    d2 = 0;
    for (int i = 0; i < 3; i++) begin
      dm[i] = (dv[i] < 0) ? longint'(-dv[i]) : dv[i];
      d2 += (dm[i] * dm[i]) >> 16;
    end
    m2 = (longint'(min_dist_q) * longint'(min_dist_q)) >> 16;
    if (d2 < m2) d2 = m2;
    // zero distance: forces stay zero
    if (d2 == 0) return res;
    len = int_sqrt(d2 << 14);
    mm = (longint'(r.mass_a) * longint'(r.mass_b)) >> 16;
    if (mm > 64'hFFFF_FFFF) mm = 64'hFFFF_FFFF;
    kneg = strength_q < 0;
    kmag = kneg ? -longint'(strength_q) : longint'(strength_q);
    km = (kmag * mm) >> 16;
    fmag = (km << 16) / d2;
    for (int i = 0; i < 3; i++) begin
      u = (dm[i] << 29) / len;
      if (u > (64'd1 << 30)) u = 64'd1 << 30;
      ph = (fmag >> 32) * u;
      if (ph >= (64'd1 << 30)) c = 64'd1 << 33;
      else c = (ph << 2) + (((fmag & 64'hFFFF_FFFF) * u) >> 30);
      neg = (kneg != (dv[i] < 0)) && c != 0;
      fb[i] = apb ? sat_force(neg, c) : '0;
      fa[i] = apa ? sat_force(!neg && c != 0, c) : '0;
    end
    res.force_a_x = fa[0]; res.force_a_y = fa[1]; res.force_a_z = fa[2];
    res.force_b_x = fb[0]; res.force_b_y = fb[1]; res.force_b_z = fb[2];
    return res;
  endfunction

  task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  // Register shadow, request prediction and response check
  always @(posedge clk_i or negedge rst_ni) begin
    paf_rsp_t exp_r;
    if (!rst_ni) begin
      strength_q <= '0;
      min_dist_q <= '0;
      enabled_q  <= 1'b1;
      force_q.delete();
      errors_o   = 0;
      pending_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (paf_reg_e'(cfg_idx_i))
          REG_STRENGTH: strength_q <= cfg_wdata_i;
          REG_MIN_DIST: min_dist_q <= cfg_wdata_i[30:0];
          REG_ENABLED:  enabled_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (req_valid_i && req_ready_i) force_q.push_back(pair_force(req_data_i));
      if (rsp_valid_i && rsp_ready_i) begin
        if (force_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected response %h", $time, rsp_data_i);
        end else begin
          exp_r = force_q.pop_front();
          cmp_field("force_a_x", exp_r.force_a_x, rsp_data_i.force_a_x);
          cmp_field("force_a_y", exp_r.force_a_y, rsp_data_i.force_a_y);
          cmp_field("force_a_z", exp_r.force_a_z, rsp_data_i.force_a_z);
          cmp_field("force_b_x", exp_r.force_b_x, rsp_data_i.force_b_x);
          cmp_field("force_b_y", exp_r.force_b_y, rsp_data_i.force_b_y);
          cmp_field("force_b_z", exp_r.force_b_z, rsp_data_i.force_b_z);
          cmp_field("apply_a", 32'(exp_r.apply_a), 32'(rsp_data_i.apply_a));
          cmp_field("apply_b", 32'(exp_r.apply_b), 32'(rsp_data_i.apply_b));
        end
      end
      pending_o <= force_q.size();
    end
  end

endmodule

// File: tb/tb_pairwise_attraction_force.sv
`timescale 1ns / 1ps

module tb_pairwise_attraction_force;
  import paf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PIPE_DRAIN = 120;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  int errors, pending;
  bit calm = 1'b0;        // no idling on either side
  bit long_stall_go = 1'b0;

  paf_stream_if #(.T(paf_req_t)) req_if ();
  paf_stream_if #(.T(paf_rsp_t)) rsp_if ();

  always #2 clk_i = ~clk_i;

  pairwise_attraction_force uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  paf_force_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_if.valid),
    .req_ready_i(req_if.ready),
    .req_data_i (req_if.data),
    .rsp_valid_i(rsp_if.valid),
    .rsp_ready_i(rsp_if.ready),
    .rsp_data_i (rsp_if.data),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // mostly no gap, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random back-pressure plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    static int hold = 0;
    static bit stall_done = 1'b0;
    int n;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold > 0) begin
      hold--;
      rsp_if.ready <= 1'b0;
    end else if (long_stall_go && !stall_done) begin
      stall_done = 1'b1;
      hold = 400;
      rsp_if.ready <= 1'b0;
    end else begin
      n = gap_len();
      if (n > 0) hold = n - 1;
      rsp_if.ready <= (n == 0);
    end
  end

  task automatic send_pair(paf_req_t r);
    bit ok;
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do begin
      @(negedge clk_i);
      ok = req_if.ready;
      @(posedge clk_i);
    end while (!ok);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] k, logic [30:0] md, logic en);
    write_reg(REG_STRENGTH, k);
    write_reg(REG_MIN_DIST, {1'b0, md});
    write_reg(REG_ENABLED, {31'b0, en});
  endtask

  function automatic paf_req_t make_pair(logic signed [31:0] ax, ay, az, bx, by, bz,
                                         logic [30:0] ma, mb, logic fa, fb);
    paf_req_t r;
    r = '{ax, ay, az, bx, by, bz, ma, mb, fa, fb};
    return r;
  endfunction

  // mostly nearby particles, sometimes anywhere
  function automatic paf_req_t rand_pair();
    paf_req_t r;
    logic signed [31:0] p[6];
    int span;
    span = $urandom_range(0, 3);
    for (int i = 0; i < 6; i++) begin
      case (span)
        0: p[i] = $urandom;
        1: p[i] = $signed($urandom_range(0, 32'h0000_FFFF)) - 32'sh0000_8000;
        default: p[i] = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      endcase
    end
    r = make_pair(p[0], p[1], p[2], p[3], p[4], p[5],
                  ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h3_FFFF)),
                  ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h3_FFFF)),
                  $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
    return r;
  endfunction

  task automatic random_phase(int count, bit stall);
    for (int i = 0; i < count; i++) begin
      if (stall && i == 20) long_stall_go = 1'b1;
      if (i == count / 2) drain();  // sender pause until all results are back
      idle_gap(gap_len());
      send_pair(rand_pair());
    end
    drain();
  endtask

  localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PMIN = 32'sh8000_0000;
  localparam logic [30:0]        MMAX = 31'h7FFF_FFFF;
  localparam logic [30:0]        ONE  = 31'h0001_0000;

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset registers first (zero strength)
    send_pair(make_pair(ONE, 0, 0, 0, 0, 0, ONE, ONE, 1, 1));
    drain();
    set_regs(32'h0001_0000, '0, 1'b1);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_pair(make_pair(ONE, 0, 0, 0, 0, 0, ONE, ONE, 1, 1));
    send_pair(make_pair(0, ONE, 0, 0, 0, 0, ONE, ONE, 1, 0));
    send_pair(make_pair(0, 0, -$signed({1'b0, ONE}), 0, 0, 0, ONE, ONE, 0, 1));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, ONE, ONE, 1, 1));   // coincident
    send_pair(make_pair(1, 0, 0, 0, 0, 0, ONE, ONE, 1, 1));   // truncates to zero
    send_pair(make_pair(PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, MMAX, MMAX, 1, 1));
    send_pair(make_pair(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, MMAX, MMAX, 1, 1));
    send_pair(make_pair(2, 0, 3, 0, 1, 0, MMAX, MMAX, 1, 1)); // tiny distance
    send_pair(make_pair(PMAX, 0, 0, PMAX, 0, 0, MMAX, MMAX, 0, 0));
    send_pair(make_pair(ONE, ONE, ONE, 0, 0, 0, 0, MMAX, 1, 1));
    drain();
    set_regs(32'h7FFF_FFFF, MMAX, 1'b1);
    send_pair(make_pair(0, 0, 0, 0, 0, 0, MMAX, MMAX, 1, 1)); // clamped
    send_pair(make_pair(ONE, 0, 0, 0, 0, 0, MMAX, MMAX, 1, 1));
    send_pair(make_pair(PMIN, 0, 0, PMAX, 0, 0, MMAX, MMAX, 1, 1));
    drain();
    set_regs(32'h8000_0000, ONE, 1'b1);
    send_pair(make_pair(0, 0, 0, 0, 0, 0, MMAX, MMAX, 1, 1));
    send_pair(make_pair(2, -3, 5, 0, 0, 0, MMAX, MMAX, 1, 1));
    send_pair(make_pair(PMAX, PMIN, 0, PMIN, PMAX, 0, ONE, ONE, 1, 1));
    drain();
    set_regs(32'hFFFF_0000, ONE, 1'b0);                       // disabled
    send_pair(make_pair(ONE, 0, 0, 0, 0, 0, ONE, ONE, 1, 1));
    send_pair(make_pair(PMAX, 0, 0, PMIN, 0, 0, MMAX, MMAX, 0, 1));
    drain();

    // Random phases over a spread of register settings
    set_regs(32'h0001_0000, '0, 1'b1);
    random_phase(300, 1'b1);
    set_regs(32'h7FFF_FFFF, MMAX, 1'b1);
    random_phase(200, 1'b0);
    set_regs(32'h8000_0000, 31'h0000_0100, 1'b1);
    calm = 1'b1;
    random_phase(200, 1'b0);
    calm = 1'b0;
    set_regs($urandom, 31'($urandom_range(0, 32'h0004_0000)), 1'b1);
    random_phase(300, 1'b0);
    set_regs(-$signed($urandom_range(1, 32'h0010_0000)), ONE, 1'b1);
    random_phase(300, 1'b0);
    set_regs($urandom, 31'($urandom), 1'b0);
    random_phase(100, 1'b0);
    set_regs($urandom_range(1, 32'h0100_0000), '0, 1'b1);
    random_phase(100, 1'b0);

    repeat (PIPE_DRAIN) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
